[design/tlrq_pkg.sv]
// ----------------------------------------------------------------------------
// tlrq_pkg
// Shared types and codes for the three-level ready queue.
// ----------------------------------------------------------------------------
package tlrq_pkg;
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [2:0] ST_ENQUEUED   = 3'd0;
   localparam logic [2:0] ST_DISPATCHED = 3'd1;
   localparam logic [2:0] ST_EMPTY      = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_REJECTED   = 3'd4;

   localparam logic [1:0] LVL_NONE   = 2'd0;
   localparam logic [1:0] LVL_TOP    = 2'd1;
   localparam logic [1:0] LVL_MIDDLE = 2'd2;
   localparam logic [1:0] LVL_BOTTOM = 2'd3;

   localparam logic [1:0] REG_MIDDLE_FLOOR = 2'd0;
   localparam logic [1:0] REG_TOP_FLOOR    = 2'd1;
   localparam logic [1:0] REG_CEILING      = 2'd2;

   localparam logic [7:0] MIDDLE_FLOOR_RESET = 8'd50;
   localparam logic [7:0] TOP_FLOOR_RESET    = 8'd100;
   localparam logic [7:0] CEILING_RESET      = 8'd149;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  task_id;
      logic [7:0]  task_priority;
      logic [23:0] remaining_burst;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] chosen_id;
      logic [1:0] level;
   } rsp_type;

   // classified operation handed from front to back
   typedef struct packed {
      logic        deq;
      logic        reject;
      logic [1:0]  level;
      logic [7:0]  task_id;
      logic [7:0]  task_priority;
      logic [23:0] remaining_burst;
   } op_type;
endpackage

[design/tlrq_if.sv]
// ----------------------------------------------------------------------------
// tlrq_req_if / tlrq_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tlrq_req_if import tlrq_pkg::*;;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface tlrq_rsp_if import tlrq_pkg::*;;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/tlrq_front.sv]
// ----------------------------------------------------------------------------
// tlrq_front
// Accepts items, classifies them by band and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tlrq_front import tlrq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] middle_floor,
   input  logic [7:0] top_floor,
   input  logic [7:0] ceiling,
   tlrq_req_if.sink   req,
   output logic       op_valid,
   output op_type     op,
   input  logic       op_take
);
   op_type     q_ff [2];
   op_type     q0_in;
   logic [1:0] cnt_ff, cnt_in;
   op_type     cls;
   logic       push;

   always_comb begin
      cls.deq             = (req.payload.cmd == CMD_DEQUEUE);
      cls.task_id         = req.payload.task_id;
      cls.task_priority   = req.payload.task_priority;
      cls.remaining_burst = req.payload.remaining_burst;
      cls.reject          = 1'b0;
      cls.level           = LVL_NONE;
      if (req.payload.task_priority > ceiling) begin
         cls.reject = 1'b1;
      end else if (req.payload.task_priority >= top_floor) begin
         cls.level = LVL_TOP;
      end else if (req.payload.task_priority >= middle_floor) begin
         cls.level = LVL_MIDDLE;
      end else begin
         cls.level = LVL_BOTTOM;
      end
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign op_valid  = (cnt_ff != 2'd0);
   assign op        = q_ff[0];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, op_take};
      q0_in  = q_ff[0];
      if (op_take) begin
         q0_in = (cnt_ff == 2'd2) ? q_ff[1] : cls;
      end else if (cnt_ff == 2'd0) begin
         q0_in = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff[0] <= q0_in;
      if (push && ((cnt_ff == 2'd1 && !op_take) || (cnt_ff == 2'd2))) begin
         q_ff[1] <= cls;
      end
   end
endmodule

[design/tlrq_back.sv]
// ----------------------------------------------------------------------------
// tlrq_back
// Sorted shift chains for top and middle levels, a ring for the bottom level.
// ----------------------------------------------------------------------------
module tlrq_back import tlrq_pkg::*; #(
   parameter int LEVEL_DEPTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     op_valid,
   input  op_type   op,
   output logic     op_take,
   tlrq_rsp_if.source rsp
);
   localparam int AW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CW = $clog2(LEVEL_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(LEVEL_DEPTH);

   logic [31:0]   top_ff [LEVEL_DEPTH];
   logic [15:0]   mid_ff [LEVEL_DEPTH];
   logic [7:0]    bot_mem [LEVEL_DEPTH];
   logic [CW-1:0] top_cnt_ff, mid_cnt_ff, bot_cnt_ff;
   logic [AW-1:0] bot_head_ff;
   logic          out_valid_ff;
   rsp_type       out_ff, res;
   logic [LEVEL_DEPTH-1:0] top_beat, mid_beat;
   logic [31:0]   top_new;
   logic [15:0]   mid_new;
   logic [16:0]   mid_key;
   logic          do_top_ins, do_mid_ins, do_bot_ins;
   logic          do_top_pop, do_mid_pop, do_bot_pop;
   logic [AW-1:0] bot_slot;
   logic [AW:0]   slot_sum;

   assign op_take   = op_valid && (!out_valid_ff || rsp.ready);
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   assign top_new = {op.remaining_burst, op.task_id};
   assign mid_new = {op.task_priority, op.task_id};
   assign mid_key = {1'b0, ~op.task_priority, op.task_id};

   always_comb begin
      for (int i = 0; i < LEVEL_DEPTH; i++) begin
         top_beat[i] = (CW'(i) < top_cnt_ff) && (top_new < top_ff[i]);
         mid_beat[i] = (CW'(i) < mid_cnt_ff)
                       && (mid_key < {1'b0, ~mid_ff[i][15:8], mid_ff[i][7:0]});
      end
   end

   always_comb begin
      slot_sum = {1'b0, bot_head_ff} + (AW+1)'(bot_cnt_ff);
      if (slot_sum >= (AW+1)'(LEVEL_DEPTH)) begin
         slot_sum = slot_sum - (AW+1)'(LEVEL_DEPTH);
      end
      bot_slot = slot_sum[AW-1:0];
   end

   always_comb begin
      do_top_ins = 1'b0; do_mid_ins = 1'b0; do_bot_ins = 1'b0;
      do_top_pop = 1'b0; do_mid_pop = 1'b0; do_bot_pop = 1'b0;
      res = '{status: ST_EMPTY, chosen_id: 8'd0, level: LVL_NONE};
      if (op.deq) begin
         if (top_cnt_ff != '0) begin
            do_top_pop = 1'b1;
            res = '{status: ST_DISPATCHED, chosen_id: top_ff[0][7:0], level: LVL_TOP};
         end else if (mid_cnt_ff != '0) begin
            do_mid_pop = 1'b1;
            res = '{status: ST_DISPATCHED, chosen_id: mid_ff[0][7:0], level: LVL_MIDDLE};
         end else if (bot_cnt_ff != '0) begin
            do_bot_pop = 1'b1;
            res = '{status: ST_DISPATCHED, chosen_id: bot_mem[bot_head_ff],
                    level: LVL_BOTTOM};
         end
      end else if (op.reject) begin
         res = '{status: ST_REJECTED, chosen_id: 8'd0, level: LVL_NONE};
      end else begin
         res.level  = op.level;
         res.status = ST_ENQUEUED;
         case (op.level)
            LVL_TOP: begin
               if (top_cnt_ff >= FULL) res.status = ST_FULL;
               else do_top_ins = 1'b1;
            end
            LVL_MIDDLE: begin
               if (mid_cnt_ff >= FULL) res.status = ST_FULL;
               else do_mid_ins = 1'b1;
            end
            default: begin
               if (bot_cnt_ff >= FULL) res.status = ST_FULL;
               else do_bot_ins = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_cnt_ff   <= '0;
         mid_cnt_ff   <= '0;
         bot_cnt_ff   <= '0;
         bot_head_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (op_take) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (op_take) begin
            if (do_top_ins) top_cnt_ff <= top_cnt_ff + 1'b1;
            if (do_top_pop) top_cnt_ff <= top_cnt_ff - 1'b1;
            if (do_mid_ins) mid_cnt_ff <= mid_cnt_ff + 1'b1;
            if (do_mid_pop) mid_cnt_ff <= mid_cnt_ff - 1'b1;
            if (do_bot_ins) bot_cnt_ff <= bot_cnt_ff + 1'b1;
            if (do_bot_pop) begin
               bot_cnt_ff  <= bot_cnt_ff - 1'b1;
               bot_head_ff <= (bot_head_ff == AW'(LEVEL_DEPTH - 1)) ? '0
                              : bot_head_ff + 1'b1;
            end
         end
      end
      if (op_take) out_ff <= res;
      if (op_take && do_bot_ins) bot_mem[bot_slot] <= op.task_id;
      for (int i = 0; i < LEVEL_DEPTH; i++) begin
         if (op_take && do_top_pop) begin
            if (i < LEVEL_DEPTH - 1) top_ff[i] <= top_ff[(i < LEVEL_DEPTH - 1) ? i + 1 : i];
         end else if (op_take && do_top_ins) begin
            if (top_beat[i]) begin
               if (i == 0 || !top_beat[(i > 0) ? i - 1 : 0]) top_ff[i] <= top_new;
               else top_ff[i] <= top_ff[(i > 0) ? i - 1 : 0];
            end else if (CW'(i) == top_cnt_ff) begin
               if (i == 0 || !top_beat[(i > 0) ? i - 1 : 0]) top_ff[i] <= top_new;
               else top_ff[i] <= top_ff[(i > 0) ? i - 1 : 0];
            end
         end
         if (op_take && do_mid_pop) begin
            if (i < LEVEL_DEPTH - 1) mid_ff[i] <= mid_ff[(i < LEVEL_DEPTH - 1) ? i + 1 : i];
         end else if (op_take && do_mid_ins) begin
            if (mid_beat[i] || CW'(i) == mid_cnt_ff) begin
               if (i == 0 || !mid_beat[(i > 0) ? i - 1 : 0]) mid_ff[i] <= mid_new;
               else mid_ff[i] <= mid_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end
endmodule

[design/three_level_ready_queue_unit.sv]
// ----------------------------------------------------------------------------
// three_level_ready_queue_unit
// Three-level ready queue: burst-sorted top, priority-sorted middle, FIFO bottom.
// ----------------------------------------------------------------------------
// The front classifies an item by band as it is accepted and queues it; the
// back carries it out once the result register is free or being read, and
// registers the result, which is offered from that register.
// With the result side ready, items can enter every cycle.
// Sorted levels insert and pop through a shift chain with per-entry compare.
// Register map: 0x0 middle floor, 0x4 top floor, 0x8 priority ceiling.
module three_level_ready_queue_unit import tlrq_pkg::*; #(
   parameter int LEVEL_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   tlrq_req_if.sink    req,
   tlrq_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [7:0] mid_floor_ff, top_floor_ff, ceiling_ff;
   logic       op_valid, op_take, wr;
   op_type     op;
   logic [1:0] idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_floor_ff <= MIDDLE_FLOOR_RESET;
         top_floor_ff <= TOP_FLOOR_RESET;
         ceiling_ff   <= CEILING_RESET;
      end else if (wr && csr_paddr[1:0] == 2'd0) begin
         case (idx)
            REG_MIDDLE_FLOOR: mid_floor_ff <= csr_pwdata[7:0];
            REG_TOP_FLOOR:    top_floor_ff <= csr_pwdata[7:0];
            REG_CEILING:      ceiling_ff   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_MIDDLE_FLOOR: csr_prdata = {24'd0, mid_floor_ff};
         REG_TOP_FLOOR:    csr_prdata = {24'd0, top_floor_ff};
         REG_CEILING:      csr_prdata = {24'd0, ceiling_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   tlrq_front u_front (
      .clock, .reset,
      .middle_floor(mid_floor_ff), .top_floor(top_floor_ff), .ceiling(ceiling_ff),
      .req, .op_valid, .op, .op_take
   );

   tlrq_back #(.LEVEL_DEPTH(LEVEL_DEPTH)) u_back (
      .clock, .reset, .op_valid, .op, .op_take, .rsp
   );

   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      op_take |-> op_valid) else $error("take without op");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   a_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.status != ST_DISPATCHED |-> rsp.payload.chosen_id == 8'd0)
      else $error("id without dispatch");
endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-level ready queue: random and directed
// enqueue/dequeue items with an in-order model of the levels and band
// registers, random stalls on both channels, and register phases between.
// ----------------------------------------------------------------------------
module tb_top;
   import tlrq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tlrq_req_if req ();
   tlrq_rsp_if rsp ();

   three_level_ready_queue_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   localparam int DEPTH = 16;

   logic [7:0]  mid_floor, top_floor, ceiling;
   logic [31:0] top_q[$];
   logic [15:0] mid_q[$];
   logic [7:0]  bot_q[$];

   req_type pending_items[$];
   rsp_type expected_rsp[$];

   int mismatches = 0;
   int accepted = 0;
   int dispatched = 0;
   int full_hits = 0;
   int idle_cycles = 0;
   bit hold_sink = 0;
   int gap = 0;
   int stall = 0;

   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int max_i(int a, int b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [15:0] mid_rank(logic [15:0] e);
      return {8'd255 - e[15:8], e[7:0]};
   endfunction

   function automatic rsp_type schedule(req_type it);
      rsp_type r;
      int pos;
      logic [31:0] te;
      logic [15:0] me;
      r = '{status: ST_ENQUEUED, chosen_id: 8'd0, level: LVL_NONE};
      if (it.cmd == CMD_ENQUEUE) begin
         if (it.task_priority > ceiling) begin
            r.status = ST_REJECTED;
         end else if (it.task_priority >= top_floor) begin
            r.level = LVL_TOP;
            if (top_q.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               pos = top_q.size();
               for (int i = 0; i < top_q.size(); i++)
                  if ({it.remaining_burst, it.task_id} < top_q[i]) begin
                     pos = i;
                     break;
                  end
               top_q.insert(pos, {it.remaining_burst, it.task_id});
            end
         end else if (it.task_priority >= mid_floor) begin
            r.level = LVL_MIDDLE;
            if (mid_q.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               pos = mid_q.size();
               for (int i = 0; i < mid_q.size(); i++)
                  if (mid_rank({it.task_priority, it.task_id}) < mid_rank(mid_q[i])) begin
                     pos = i;
                     break;
                  end
               mid_q.insert(pos, {it.task_priority, it.task_id});
            end
         end else begin
            r.level = LVL_BOTTOM;
            if (bot_q.size() >= DEPTH) r.status = ST_FULL;
            else bot_q.push_back(it.task_id);
         end
      end else begin
         r.status = ST_DISPATCHED;
         if (top_q.size() > 0) begin
            te = top_q.pop_front();
            r.chosen_id = te[7:0];
            r.level = LVL_TOP;
         end else if (mid_q.size() > 0) begin
            me = mid_q.pop_front();
            r.chosen_id = me[7:0];
            r.level = LVL_MIDDLE;
         end else if (bot_q.size() > 0) begin
            r.chosen_id = bot_q.pop_front();
            r.level = LVL_BOTTOM;
         end else begin
            r.status = ST_EMPTY;
         end
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.payload <= '0;
      end else begin
         if (req.valid && req.ready) begin
            expected_rsp.push_back(schedule(req.payload));
            accepted++;
         end
         if ((req.valid && !req.ready) ) begin
         end else if (gap > 0) begin
            gap--;
            req.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req.valid <= 1'b1;
            req.payload <= pending_items.pop_front();
            gap = draw_gap();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp.payload);
            end else begin
               rsp_type e;
               e = expected_rsp.pop_front();
               if (rsp.payload.status == ST_DISPATCHED) dispatched++;
               if (rsp.payload.status == ST_FULL) full_hits++;
               if (rsp.payload !== e) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected st=%0d id=%0d lvl=%0d got st=%0d id=%0d lvl=%0d",
                        e.status, e.chosen_id, e.level, rsp.payload.status,
                        rsp.payload.chosen_id, rsp.payload.level);
               end
            end
         end
         if (hold_sink) begin
            rsp.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            stall = draw_gap();
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_sink)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'd0, val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_MIDDLE_FLOOR: mid_floor = val;
         REG_TOP_FLOOR:    top_floor = val;
         default:          ceiling = val;
      endcase
   endtask

   task automatic set_bands(logic [7:0] m, logic [7:0] t, logic [7:0] c);
      write_reg(REG_MIDDLE_FLOOR, m);
      write_reg(REG_TOP_FLOOR, t);
      write_reg(REG_CEILING, c);
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || req.valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic req_type make_item(logic c, logic [7:0] id, logic [7:0] p,
                                        logic [23:0] b);
      req_type it;
      it.cmd = c;
      it.task_id = id;
      it.task_priority = p;
      it.remaining_burst = b;
      return it;
   endfunction

   function automatic req_type rand_item(int deq_pct);
      req_type it;
      int r;
      it.cmd = ($urandom_range(0, 99) < deq_pct) ? CMD_DEQUEUE : CMD_ENQUEUE;
      it.task_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      r = $urandom_range(0, 9);
      it.task_priority = (r < 3) ? 8'($urandom_range(max_i(0, top_floor - 3), top_floor + 3))
                       : (r < 5) ? 8'($urandom_range(max_i(0, mid_floor - 3), mid_floor + 3))
                       : 8'($urandom);
      it.remaining_burst = ($urandom_range(0, 2) == 0) ? 24'($urandom_range(0, 7))
                         : 24'($urandom);
      return it;
   endfunction

   initial begin
      mid_floor = MIDDLE_FLOOR_RESET;
      top_floor = TOP_FLOOR_RESET;
      ceiling = CEILING_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty dequeue, bands, ties, rejection, burst extremes
      pending_items.push_back(make_item(CMD_DEQUEUE, 8'd0, 8'd0, 24'd0));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd9, 8'd149, 24'hFFFFFF));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd3, 8'd100, 24'h000000));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd3, 8'd120, 24'h000000));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd1, 8'd110, 24'h000000));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd7, 8'd99, 24'd5));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd2, 8'd99, 24'd5));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd2, 8'd99, 24'd6));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd8, 8'd50, 24'd0));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'hFF, 8'd49, 24'd1));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd0, 8'd0, 24'd1));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd4, 8'd150, 24'd1));
      pending_items.push_back(make_item(CMD_ENQUEUE, 8'd4, 8'd255, 24'hAAAAAA));
      repeat (12) pending_items.push_back(make_item(CMD_DEQUEUE, 8'hFF, 8'hFF, 24'h555555));
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_bands(8'd0, 8'd255, 8'd255);
            1: set_bands(8'd200, 8'd100, 8'd255);
            2: set_bands(8'd0, 8'd0, 8'd0);
            3: set_bands(8'd255, 8'd255, 8'd254);
            4: set_bands(8'($urandom_range(0, 120)), 8'($urandom_range(100, 200)),
                         8'($urandom_range(150, 255)));
            default: set_bands(MIDDLE_FLOOR_RESET, TOP_FLOOR_RESET, CEILING_RESET);
         endcase
         // fill past full, then mix
         repeat (60) pending_items.push_back(rand_item(15));
         repeat (190) pending_items.push_back(rand_item(50));
         if (ph == 5) begin
            while (pending_items.size() > 0) @(posedge clock);
            hold_sink = 1;
            repeat (300) pending_items.push_back(rand_item(45));
            repeat (200) @(posedge clock);
            hold_sink = 0;
         end
         drain();
      end

      $display("covered %0d items over six band settings: %0d dispatched, %0d full levels",
         accepted, dispatched, full_hits);
      $display("with random stalls on both sides and one long result-side hold");
      if (mismatches == 0 && expected_rsp.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   final begin
   end
endmodule

[files.f]
design/tlrq_pkg.sv
design/tlrq_if.sv
design/tlrq_front.sv
design/tlrq_back.sv
design/three_level_ready_queue_unit.sv
tb/tb_top.sv
